/* rtl/i2p_pkg.sv */
`default_nettype none

package i2p_pkg;

  // Operator and terminator characters
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_TERM = 8'h00;

  // Letter range bounds
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;

  // Precedence levels
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_FLUSH,
    S_TERM
  } state_t;

  typedef enum logic [1:0] {
    SEL_SYM,
    SEL_TOP,
    SEL_ZERO
  } emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      latch;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      emit_done;
    logic      pop;
    logic      push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_letter;
    logic is_op;
    logic expr_end;
    logic pop_cond;
    logic next_pop;
    logic count_nz;
    logic count_one;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    r = RANK_NONE;
    if (ch == CH_MUL || ch == CH_DIV) begin
      r = RANK_MUL;
    end else if (ch == CH_ADD || ch == CH_SUB) begin
      r = RANK_ADD;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

endpackage

`default_nettype wire

/* rtl/infix_to_postfix_converter.sv */
// A letter's result word is loaded into the output register from the held-symbol register
// in S_DECIDE; a popped operator is emitted from S_POP or S_FLUSH, the terminator from S_TERM.
// Each item goes through accept, decode, one emit per result word (up to four), and a push
// for an operator; the single-issue controller takes no new item until it is through with the last.
// Output stalls hold the controller in place; a result word can wait while work goes on.
// Reset (rst_n low, synchronous) empties the operator stack and the output register.
`default_nettype none

module infix_to_postfix_converter
  import i2p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tlast,   // expression_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_symbol
  output logic            out_tlast,  // run_last
  output logic            out_tuser   // [0] expression_done
);

  cmd_t cmd;
  sts_t sts;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2p_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* rtl/i2p_datapath.sv */
`default_nettype none

module i2p_datapath
  import i2p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);

  logic [7:0] sym_r;
  logic       end_r;
  logic [7:0] stack_r [2];
  logic [1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_sym_r;
  logic       out_last_r;
  logic       out_done_r;
  logic [7:0] top;
  logic [7:0] emit_val;
  logic [1:0] sym_rank;

  // Top of stack and rank of the held symbol
  assign top      = (count_r == 2'd2) ? stack_r[1] : stack_r[0];
  assign sym_rank = rank_of(sym_r);

  // Status toward the controller
  always_comb begin
    sts.is_letter = is_letter(sym_r);
    sts.is_op     = (sym_rank != RANK_NONE);
    sts.expr_end  = end_r;
    sts.pop_cond  = (count_r != 2'd0) && (rank_of(top) >= sym_rank);
    sts.next_pop  = (count_r == 2'd2) && (rank_of(stack_r[0]) >= sym_rank);
    sts.count_nz  = (count_r != 2'd0);
    sts.count_one = (count_r == 2'd1);
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r <= in_tdata;
      end_r <= in_tlast;
    end
  end

  // Push the held operator; drop the push on a full stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (count_r == 2'd0) begin
        stack_r[0] <= sym_r;
      end else if (count_r == 2'd1) begin
        stack_r[1] <= sym_r;
      end
    end
  end

  // Advance the stack depth
  always_comb begin
    count_nxt = count_r;
    if (cmd.pop && count_r != 2'd0) begin
      count_nxt = count_r - 2'd1;
    end else if (cmd.push && count_r < 2'd2) begin
      count_nxt = count_r + 2'd1;
    end
  end

  // Select the emitted character
  always_comb begin
    case (cmd.emit_sel)
      SEL_SYM:  emit_val = sym_r;
      SEL_TOP:  emit_val = top;
      SEL_ZERO: emit_val = CH_TERM;
      default:  emit_val = CH_TERM;
    endcase
  end

  // Output word register: drop on take, load on emit
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sym_r  <= emit_val;
      out_last_r <= cmd.emit_last;
      out_done_r <= cmd.emit_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire

/* rtl/i2p_ctrl.sv */
`default_nettype none

module i2p_ctrl
  import i2p_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.latch     = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_sel  = SEL_SYM;
    cmd.emit_last = 1'b0;
    cmd.emit_done = 1'b0;
    cmd.pop       = 1'b0;
    cmd.push      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_letter) begin
          // pass the letter through once the output slot frees
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_SYM;
            cmd.emit_last = !sts.expr_end;
            if (!sts.expr_end) begin
              state_nxt = S_IDLE;
            end else if (sts.count_nz) begin
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_TERM;
            end
          end
        end else if (sts.is_op) begin
          state_nxt = S_POP;
        end else if (!sts.expr_end) begin
          state_nxt = S_IDLE;
        end else if (sts.count_nz) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_TERM;
        end
      end
      S_POP: begin
        if (sts.pop_cond) begin
          // pop operators of equal or higher rank
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_TOP;
            cmd.emit_last = !sts.expr_end && !sts.next_pop;
            cmd.pop       = 1'b1;
          end
        end else begin
          cmd.push  = 1'b1;
          state_nxt = sts.expr_end ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_TOP;
          cmd.pop      = 1'b1;
          if (sts.count_one) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_ZERO;
          cmd.emit_last = 1'b1;
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* verif/infix_to_postfix_converter_tb.sv */
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RANDOM_LIVE = 100;     // random characters that do something
  localparam int CALM_TAIL   = 20;      // no idling once this few characters remain
  localparam int SETTLE      = 10;      // cycles to watch for stray words at the end
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } infix_char_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       run_last;
    logic       done;
  } postfix_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] symbol
  logic       in_tlast = 1'b0;    // expression_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_symbol
  logic       out_tlast;          // run_last
  logic       out_tuser;          // [0] expression_done

  infix_char_t   pending_chars[$];
  postfix_word_t postfix_due[$];
  infix_char_t   next_char;

  // Shadow of the operator stack
  logic [7:0] op_stack [2];
  int         op_count = 0;

  int live_chars = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int in_gap = 0;
  int out_gap = 0;
  int in_odds = 0;
  int out_odds = 0;

  infix_to_postfix_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

  function automatic logic [1:0] precedence(input logic [7:0] ch);
    case (ch)
      CH_MUL, CH_DIV: return RANK_MUL;
      CH_ADD, CH_SUB: return RANK_ADD;
      default:        return RANK_NONE;
    endcase
  endfunction

  // Work out the postfix words one accepted character produces
  task automatic convert_char(input logic [7:0] sym, input logic last);
    postfix_word_t fresh[$];
    logic [1:0]    r;
    r = precedence(sym);
    if (is_alpha(sym)) begin
      fresh.push_back('{sym: sym, run_last: 1'b0, done: 1'b0});
    end else if (r != RANK_NONE) begin
      // pop equal or higher precedence, then push
      while (op_count > 0 && precedence(op_stack[op_count-1]) >= r) begin
        op_count--;
        fresh.push_back('{sym: op_stack[op_count], run_last: 1'b0, done: 1'b0});
      end
      if (op_count < 2) begin
        op_stack[op_count] = sym;
        op_count++;
      end
    end
    if (last) begin
      // flush the stack, then terminate the expression
      while (op_count > 0) begin
        op_count--;
        fresh.push_back('{sym: op_stack[op_count], run_last: 1'b0, done: 1'b0});
      end
      fresh.push_back('{sym: CH_TERM, run_last: 1'b0, done: 1'b1});
    end
    if (fresh.size() > 0) begin
      fresh[fresh.size()-1].run_last = 1'b1;
    end
    foreach (fresh[i]) postfix_due.push_back(fresh[i]);
  endtask

  task automatic queue_char(input logic [7:0] sym, input logic last = 1'b0);
    pending_chars.push_back('{sym: sym, last: last});
    if (is_alpha(sym) || precedence(sym) != RANK_NONE || last) begin
      live_chars++;
    end
  endtask

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) == 1) begin
      return CH_UP_A + 8'($urandom_range(0, 25));
    end
    return CH_LO_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(0, 3))
      0:       return CH_MUL;
      1:       return CH_DIV;
      2:       return CH_ADD;
      default: return CH_SUB;
    endcase
  endfunction

  // Reroll idling odds now and then; zero means a stretch without idling
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 100 == 0) begin
      case ($urandom_range(0, 2))
        0:       in_odds <= 0;
        1:       in_odds <= 3;
        default: in_odds <= 10;
      endcase
      case ($urandom_range(0, 2))
        0:       out_odds <= 0;
        1:       out_odds <= 3;
        default: out_odds <= 10;
      endcase
    end
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_tb: done, errors");
      $finish;
    end
  end

  // Input driver: predict on accept, hold the word until taken, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        convert_char(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_chars.size() > CALM_TAIL && in_odds != 0 &&
                     $urandom_range(1, in_odds) == 1) begin
          in_gap    <= $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          next_char = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_char.sym;
          in_tlast  <= next_char.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: stall in bursts while enough stimulus remains
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_gap != 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (pending_chars.size() > CALM_TAIL && out_odds != 0 &&
                 $urandom_range(1, out_odds) == 1) begin
      out_gap    <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    postfix_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (postfix_due.size() == 0) begin
        if (errors < REPORT_MAX) begin
          $display("unexpected word: sym=%h last=%b done=%b",
                   out_tdata, out_tlast, out_tuser);
        end
        errors++;
      end else begin
        want = postfix_due.pop_front();
        if (out_tdata !== want.sym || out_tlast !== want.run_last ||
            out_tuser !== want.done) begin
          if (errors < REPORT_MAX) begin
            $display("mismatch: sym=%h/%h last=%b/%b done=%b/%b (expected/actual)",
                     want.sym, out_tdata, want.run_last, out_tlast,
                     want.done, out_tuser);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    int kind;
    int terms;
    int len;

    // Directed: field extremes, every operator, pops, flushes, dropped characters
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char("A");
    queue_char(CH_MUL);
    queue_char("Z");
    queue_char(CH_ADD);            // pops the multiply
    queue_char("a");
    queue_char(CH_DIV);            // stacks above the add
    queue_char("z");
    queue_char(CH_SUB);            // pops two operators
    queue_char(8'h40);             // just below the uppercase range
    queue_char("b", 1'b1);
    queue_char("c");
    queue_char(CH_SUB);
    queue_char("d");
    queue_char(CH_MUL);
    queue_char("e", 1'b1);         // letter, two flushed operators, terminator
    queue_char("f");
    queue_char(CH_ADD);
    queue_char(8'h7B, 1'b1);       // end carried by a dropped character
    queue_char(8'h5B, 1'b1);       // empty expression
    queue_char("g");
    queue_char(CH_DIV, 1'b1);      // end on an operator
    queue_char(CH_SUB);            // operator with nothing before it
    queue_char(8'h60);
    queue_char("h", 1'b1);

    // Random: mostly well-formed expressions, some noise and broken ones
    live_chars = 0;
    while (live_chars < RANDOM_LIVE) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 2))
            0:       queue_char(any_letter(), i == len - 1);
            1:       queue_char(any_operator(), i == len - 1);
            default: queue_char(8'($urandom_range(0, 255)), i == len - 1);
          endcase
        end
      end else begin
        terms = $urandom_range(1, 5);
        for (int i = 0; i < terms; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            queue_char(8'($urandom_range(0, 255)));
          end
          queue_char(any_letter(), i == terms - 1);
          if (i != terms - 1) begin
            queue_char(any_operator());
          end
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all characters taken and every predicted word seen
    while (pending_chars.size() != 0 || in_tvalid || postfix_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("infix_to_postfix_converter_tb: done, clean");
    end else begin
      $display("infix_to_postfix_converter_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/i2p_pkg.sv
rtl/i2p_datapath.sv
rtl/i2p_ctrl.sv
rtl/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_tb.sv
